// ===== design/alu16_pkg.sv =====
package alu16_pkg;

    localparam int WIDTH = 16;
    // quotient bits resolved per pipeline stage
    localparam int DIV_BITS_PER_STAGE = 4;
    // divide stages after the first compute stage
    localparam int DIV_LATE_STAGES = WIDTH / DIV_BITS_PER_STAGE - 1;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_AND = 4'd4,
        CMD_OR  = 4'd5,
        CMD_XOR = 4'd6,
        CMD_NOT = 4'd7,
        CMD_SHL = 4'd8,
        CMD_SHR = 4'd9,
        CMD_CMP = 4'd10
    } t_cmd;

    // One item in flight. rq holds the result in its low half; for multiply
    // it is the full product, for divide the remainder/quotient shift pair.
    typedef struct packed {
        logic               valid;
        logic [3:0]         cmd;
        logic [WIDTH-1:0]   b;
        logic [2*WIDTH-1:0] rq;
        logic               c;
        logic               v;
    } t_stage;

    // Restoring division, four quotient bits per call. Divisor zero yields all ones.
    function automatic logic [2*WIDTH-1:0] div_step(input logic [2*WIDTH-1:0] rq,
                                                     input logic [WIDTH-1:0]   dvs);
        logic [2*WIDTH:0] acc;
        acc = {1'b0, rq};
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
            acc = {acc[2*WIDTH-1:0], 1'b0};
            if (acc[2*WIDTH:WIDTH] >= {1'b0, dvs}) begin
                acc[2*WIDTH:WIDTH] = acc[2*WIDTH:WIDTH] - {1'b0, dvs};
                acc[0] = 1'b1;
            end
        end
        return acc[2*WIDTH-1:0];
    endfunction

endpackage

// ===== design/alu16_div.sv =====
module alu16_div import alu16_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    output t_stage o_stage
);

    t_stage r_st [DIV_LATE_STAGES];
    t_stage n_st [DIV_LATE_STAGES];

    always_comb begin
        for (int k = 0; k < DIV_LATE_STAGES; k++) begin
            n_st[k] = (k == 0) ? i_stage : r_st[(k == 0) ? 0 : k - 1];
            if (n_st[k].cmd == CMD_DIV) begin
                n_st[k].rq = div_step(n_st[k].rq, n_st[k].b);
            end
        end
    end

    // every stage clears on reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_LATE_STAGES; k++) begin
            if (!i_rst_n) begin
                r_st[k] <= '0;
            end else begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_stage = r_st[DIV_LATE_STAGES-1];

endmodule

// ===== design/alu_16bit_with_flags.sv =====
// 16-bit ALU with Z/N/C/V flags. One item is accepted every clock (o_busy is
// always low) and its result leaves the output register with o_valid
// high for one cycle; results come out in order. There is no ready input:
// the receiver cannot stall and must take each result in the cycle it is
// shown. Six register stages: an input register, a compute stage (add/sub,
// 16x16 multiply, logic, shifts and the first four quotient bits), three
// further divide stages of four quotient bits each, and an output register
// that forms the flags. The divider's sixteen dependent steps set the depth.
// Unused commands give a zero result with all flags clear and
// o_result_written low.
module alu_16bit_with_flags import alu16_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [3:0]  i_command,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    output logic        o_valid,
    output logic [15:0] o_result_value,
    output logic        o_result_written,
    output logic        o_zero_flag,
    output logic        o_negative_flag,
    output logic        o_carry_flag,
    output logic        o_overflow_flag
);

    // fully pipelined and no back-pressure from the receiver
    assign o_busy = 1'b0;

    // ---------------- stage 0: input register ----------------
    logic             r_s0_valid;
    logic [3:0]       r_s0_cmd;
    logic [WIDTH-1:0] r_s0_a;
    logic [WIDTH-1:0] r_s0_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_start && !o_busy;
        end
        r_s0_cmd <= i_command;
        r_s0_a   <= i_operand_a;
        r_s0_b   <= i_operand_b;
    end

    // ---------------- stage 1: compute ----------------
    logic [WIDTH:0]     sum;
    logic [WIDTH:0]     diff;
    logic [2*WIDTH-1:0] prod;
    logic [2*WIDTH-1:0] shl_ext;
    logic [2*WIDTH-1:0] shr_ext;
    logic               shift_ok;
    t_stage             n_s1;
    t_stage             r_s1;

    always_comb begin
        sum      = {1'b0, r_s0_a} + {1'b0, r_s0_b};
        diff     = {1'b0, r_s0_a} - {1'b0, r_s0_b};   // bit WIDTH is the borrow
        prod     = r_s0_a * r_s0_b;
        // count of 0..WIDTH; bit WIDTH / WIDTH-1 of the extension is the bit
        // shifted out last
        shl_ext  = {{WIDTH{1'b0}}, r_s0_a} << r_s0_b[4:0];
        shr_ext  = {r_s0_a, {WIDTH{1'b0}}} >> r_s0_b[4:0];
        shift_ok = (r_s0_b <= WIDTH[WIDTH-1:0]);

        n_s1       = '0;
        n_s1.valid = r_s0_valid;
        n_s1.cmd   = r_s0_cmd;
        n_s1.b     = r_s0_b;

        case (r_s0_cmd) inside
            CMD_ADD: begin
                n_s1.rq[WIDTH-1:0] = sum[WIDTH-1:0];
                n_s1.c = sum[WIDTH];
                n_s1.v = (r_s0_a[WIDTH-1] ^ sum[WIDTH-1]) & (r_s0_b[WIDTH-1] ^ sum[WIDTH-1]);
            end
            CMD_SUB, CMD_CMP: begin
                n_s1.rq[WIDTH-1:0] = diff[WIDTH-1:0];
                n_s1.c = diff[WIDTH];
                n_s1.v = (r_s0_a[WIDTH-1] ^ r_s0_b[WIDTH-1])
                       & (r_s0_a[WIDTH-1] ^ diff[WIDTH-1]);
            end
            CMD_MUL: begin
                // carry from the high half is formed at the output stage
                n_s1.rq = prod;
            end
            CMD_DIV: begin
                n_s1.rq = div_step({{WIDTH{1'b0}}, r_s0_a}, r_s0_b);
                n_s1.c  = (r_s0_b == '0);
            end
            CMD_AND: n_s1.rq[WIDTH-1:0] = r_s0_a & r_s0_b;
            CMD_OR:  n_s1.rq[WIDTH-1:0] = r_s0_a | r_s0_b;
            CMD_XOR: n_s1.rq[WIDTH-1:0] = r_s0_a ^ r_s0_b;
            CMD_NOT: n_s1.rq[WIDTH-1:0] = ~r_s0_a;
            CMD_SHL: begin
                if (shift_ok) begin
                    n_s1.rq[WIDTH-1:0] = shl_ext[WIDTH-1:0];
                    n_s1.c = shl_ext[WIDTH];
                end
            end
            CMD_SHR: begin
                if (shift_ok) begin
                    n_s1.rq[WIDTH-1:0] = shr_ext[2*WIDTH-1:WIDTH];
                    n_s1.c = shr_ext[WIDTH-1];
                end
            end
            default: ;  // unused codes: zero result, flags clear
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- stages 2..4: remaining quotient bits ----------------
    t_stage w_s4;

    alu16_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (r_s1),
        .o_stage (w_s4)
    );

    // ---------------- stage 5: flags and output register ----------------
    logic [WIDTH-1:0] res;
    logic             known;
    logic             carry;

    always_comb begin
        res   = w_s4.rq[WIDTH-1:0];
        known = (w_s4.cmd <= CMD_CMP);
        carry = (w_s4.cmd == CMD_MUL) ? |w_s4.rq[2*WIDTH-1:WIDTH] : w_s4.c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_s4.valid;
        end
        o_result_value   <= res;
        o_result_written <= known && (w_s4.cmd != CMD_CMP);
        o_zero_flag      <= known && (res == '0);
        o_negative_flag  <= res[WIDTH-1];
        o_carry_flag     <= carry;
        o_overflow_flag  <= w_s4.v;
    end

endmodule

// ===== design/alu16_chk.sv =====
module alu16_chk import alu16_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [3:0]  i_command,
    input logic [15:0] i_operand_a,
    input logic [15:0] i_operand_b,
    input logic        o_valid,
    input logic [15:0] o_result_value,
    input logic        o_result_written,
    input logic        o_zero_flag,
    input logic        o_negative_flag,
    input logic        o_carry_flag,
    input logic        o_overflow_flag
);

    // cycles out of reset, saturating at the pipeline depth
    logic [2:0] r_rst_age;
    logic       run6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_age <= '0;
        end else if (r_rst_age != 3'd6) begin
            r_rst_age <= r_rst_age + 3'd1;
        end
    end

    assign run6 = i_rst_n && (r_rst_age == 3'd6);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk)
        run6 |-> (o_valid == $past(i_start && !o_busy, 6)))
        else $error("result strobe not six edges after accept");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_flag) |-> (o_result_value == '0))
        else $error("zero flag with nonzero result");

    a_ovf_cmd: assert property (@(posedge i_clk)
        (run6 && o_valid && o_overflow_flag) |->
            ($past(i_command, 6) == CMD_ADD || $past(i_command, 6) == CMD_SUB
             || $past(i_command, 6) == CMD_CMP))
        else $error("overflow flag on a non-arithmetic command");

endmodule

bind alu_16bit_with_flags alu16_chk u_chk (.*);
